FILE: rtl/qlm_pkg.sv
package qlm_pkg;

    localparam int SAMPLE_BITS  = 12;
    localparam int OUTPUT_BITS  = 16;
    localparam int BAND_BITS    = 7;
    localparam int TABLE_LENGTH = 200;
    localparam int ROM_LEN      = 200;
    localparam int QUARTER      = ROM_LEN / 4;
    localparam int PH_BITS      = $clog2(TABLE_LENGTH);
    localparam int QI_BITS      = $clog2(QUARTER + 1);
    localparam int ROM_BITS     = 32;
    // cos scaled 2^30, rounded and shifted by the sample width, needs sign + 31 - SAMPLE_BITS
    localparam int LO_BITS      = ROM_BITS - SAMPLE_BITS;
    localparam int PROD_BITS    = SAMPLE_BITS + LO_BITS;
    localparam int PROD_SHIFT   = 30 - OUTPUT_BITS;

    typedef logic signed [SAMPLE_BITS-1:0] t_sample;
    typedef logic signed [LO_BITS-1:0]     t_lo;
    typedef logic signed [OUTPUT_BITS-1:0] t_mix;
    typedef logic [PH_BITS-1:0]            t_phase;

    localparam logic signed [ROM_BITS-1:0] QUARTER_ROM [QUARTER+1] = '{
        32'sh40000000, 32'sh3ff7ea5d, 32'sh3fdfab80, 32'sh3fb74988, 32'sh3f7ecea9,
        32'sh3f364928, 32'sh3eddcb58, 32'sh3e756b94, 32'sh3dfd443a, 32'sh3d7573a6,
        32'sh3cde1c27, 32'sh3c3763f9, 32'sh3b81753c, 32'sh3abc7de6, 32'sh39e8afba,
        32'sh3906403a, 32'sh3815689d, 32'sh371665ba, 32'sh360977ff, 32'sh34eee35c,
        32'sh33c6ef37, 32'sh3291e654, 32'sh315016c7, 32'sh3001d1dc, 32'sh2ea76c08,
        32'sh2d413ccd, 32'sh2bcf9eaa, 32'sh2a52ef01, 32'sh28cb8dfd, 32'sh2739de82,
        32'sh259e4609, 32'sh23f92c8f, 32'sh224afc78, 32'sh20942272, 32'sh1ed50d5d,
        32'sh1d0e2e2b, 32'sh1b3ff7c9, 32'sh196adefc, 32'sh178f5a49, 32'sh15ade1d0,
        32'sh13c6ef37, 32'sh11dafd83, 32'sh0fea88fd, 32'sh0df60f12, 32'sh0bfe0e33,
        32'sh0a0305b4, 32'sh080575af, 32'sh0605dee0, 32'sh0404c287, 32'sh0202a246,
        32'sh00000000
    };

    // Full-wave cosine from the quarter table, rounded and shifted by the sample width.
    // k is always below ROM_LEN.
    function automatic t_lo lo_value(input t_phase k);
        t_phase                       f;
        logic                         neg;
        logic signed [ROM_BITS-1:0]   c;
        f   = k;
        neg = 1'b0;
        if (f > PH_BITS'(ROM_LEN / 2)) begin
            f = PH_BITS'(ROM_LEN) - f;
        end
        if (f > PH_BITS'(QUARTER)) begin
            f   = PH_BITS'(ROM_LEN / 2) - f;
            neg = 1'b1;
        end
        c = QUARTER_ROM[f[QI_BITS-1:0]];
        if (neg) begin
            c = -c;
        end
        c = c + (32'sd1 <<< (SAMPLE_BITS - 1));
        c = c >>> SAMPLE_BITS;
        return t_lo'(c[LO_BITS-1:0]);
    endfunction

endpackage

FILE: rtl/qlm_mixer.sv
module qlm_mixer (
    input  qlm_pkg::t_sample i_sample,
    input  qlm_pkg::t_lo     i_lo,
    output qlm_pkg::t_mix    o_mix
);
    import qlm_pkg::*;

    localparam int SHIFTED_BITS = PROD_BITS - PROD_SHIFT;

    logic signed [PROD_BITS-1:0]    prod;
    logic signed [PROD_BITS-1:0]    rounded;
    logic signed [SHIFTED_BITS-1:0] shifted;

    localparam logic signed [SHIFTED_BITS-1:0] MAX_OUT = SHIFTED_BITS'((1 << (OUTPUT_BITS - 1)) - 1);
    localparam logic signed [SHIFTED_BITS-1:0] MIN_OUT = -SHIFTED_BITS'(1 << (OUTPUT_BITS - 1));

    always_comb begin
        prod    = PROD_BITS'(i_sample) * PROD_BITS'(i_lo);
        rounded = prod + (PROD_BITS'(1) <<< (PROD_SHIFT - 1));
        shifted = SHIFTED_BITS'(rounded >>> PROD_SHIFT);
        // only full-scale negative sample times -1.0 can overshoot
        if (shifted > MAX_OUT) begin
            o_mix = t_mix'(MAX_OUT[OUTPUT_BITS-1:0]);
        end else if (shifted < MIN_OUT) begin
            o_mix = t_mix'(MIN_OUT[OUTPUT_BITS-1:0]);
        end else begin
            o_mix = t_mix'(shifted[OUTPUT_BITS-1:0]);
        end
    end

endmodule

FILE: rtl/quadrature_lut_mixer_unit.sv
// An accepted input beat passes the LO lookup stage, then the multiply stage and its result register.
// Throughput: one beat per cycle while m_axis_tready is high.
// Each stage stalls on its own, so a new beat is taken while a result waits.
// Reset (i_rst_n low, synchronous) clears both stage valids, band and phase.
// A band write also clears the phase.
module quadrature_lut_mixer_unit (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [qlm_pkg::BAND_BITS-1:0]   i_cfg_wdata,   // band
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [15:0]                     s_axis_tdata,  // [11:0] rf_sample, rest zero
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [31:0]                     m_axis_tdata   // [15:0] in_phase, [31:16] quadrature
);
    import qlm_pkg::*;

    logic [BAND_BITS-1:0] r_band;
    t_phase               r_phase;
    t_phase               n_phase;

    logic    r_s1_valid;
    t_sample r_s1_sample;
    t_lo     r_s1_lo_i;
    t_lo     r_s1_lo_q;

    logic r_out_valid;
    t_mix r_out_i;
    t_mix r_out_q;

    logic               out_ready;
    logic               s1_ready;
    logic               in_fire;
    logic [PH_BITS:0]   step_sum;
    logic [PH_BITS:0]   q_sum;
    t_phase             q_phase;
    t_mix               mix_i;
    t_mix               mix_q;

    assign out_ready     = !r_out_valid || m_axis_tready;
    assign s1_ready      = !r_s1_valid || out_ready;
    assign s_axis_tready = s1_ready;
    assign in_fire       = s_axis_tvalid && s1_ready;

    always_comb begin
        step_sum = {1'b0, r_phase} + (PH_BITS + 1)'(r_band);
        if (step_sum >= (PH_BITS + 1)'(TABLE_LENGTH)) begin
            step_sum = step_sum - (PH_BITS + 1)'(TABLE_LENGTH);
        end
        n_phase = step_sum[PH_BITS-1:0];

        q_sum = {1'b0, r_phase} + (PH_BITS + 1)'(TABLE_LENGTH / 4);
        if (q_sum >= (PH_BITS + 1)'(TABLE_LENGTH)) begin
            q_sum = q_sum - (PH_BITS + 1)'(TABLE_LENGTH);
        end
        q_phase = q_sum[PH_BITS-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_band  <= '0;
            r_phase <= '0;
        end else if (i_cfg_we) begin
            r_band  <= i_cfg_wdata;
            r_phase <= '0;
        end else if (in_fire) begin
            r_phase <= n_phase;
        end
    end

    // stage 1: sample and both LO values
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (s1_ready) begin
            r_s1_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_s1_sample <= t_sample'(s_axis_tdata[SAMPLE_BITS-1:0]);
            r_s1_lo_i   <= lo_value(r_phase);
            r_s1_lo_q   <= lo_value(q_phase);
        end
    end

    qlm_mixer u_mix_i (
        .i_sample (r_s1_sample),
        .i_lo     (r_s1_lo_i),
        .o_mix    (mix_i)
    );

    qlm_mixer u_mix_q (
        .i_sample (r_s1_sample),
        .i_lo     (r_s1_lo_q),
        .o_mix    (mix_q)
    );

    // stage 2: result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_ready) begin
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_ready && r_s1_valid) begin
            r_out_i <= mix_i;
            r_out_q <= mix_q;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {r_out_q, r_out_i};

endmodule

FILE: sim/tb_quadrature_lut_mixer_unit.sv
`timescale 1ns / 100ps

module tb_quadrature_lut_mixer_unit;

    import qlm_pkg::*;

    typedef struct packed {
        t_mix in_phase;
        t_mix quadrature;
    } t_mix_beat;

    // quarter-wave cosine, scaled 2^30
    localparam longint COS_QTR [51] = '{
        'h40000000, 'h3ff7ea5d, 'h3fdfab80, 'h3fb74988, 'h3f7ecea9, 'h3f364928,
        'h3eddcb58, 'h3e756b94, 'h3dfd443a, 'h3d7573a6, 'h3cde1c27, 'h3c3763f9,
        'h3b81753c, 'h3abc7de6, 'h39e8afba, 'h3906403a, 'h3815689d, 'h371665ba,
        'h360977ff, 'h34eee35c, 'h33c6ef37, 'h3291e654, 'h315016c7, 'h3001d1dc,
        'h2ea76c08, 'h2d413ccd, 'h2bcf9eaa, 'h2a52ef01, 'h28cb8dfd, 'h2739de82,
        'h259e4609, 'h23f92c8f, 'h224afc78, 'h20942272, 'h1ed50d5d, 'h1d0e2e2b,
        'h1b3ff7c9, 'h196adefc, 'h178f5a49, 'h15ade1d0, 'h13c6ef37, 'h11dafd83,
        'h0fea88fd, 'h0df60f12, 'h0bfe0e33, 'h0a0305b4, 'h080575af, 'h0605dee0,
        'h0404c287, 'h0202a246, 'h00000000
    };

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        i_cfg_we      = 1'b0;
    logic [6:0]  i_cfg_wdata   = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata  = '0;   // [11:0] rf_sample, rest zero
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;         // [15:0] in_phase, [31:16] quadrature

    t_sample     rf_q[$];
    t_mix_beat   mix_expect_q[$];

    logic [7:0]  osc_phase = '0;
    logic [6:0]  osc_band  = '0;

    int          err_count = 0;
    int          n_checked = 0;
    int          n_writes  = 0;
    int          src_gap   = 0;
    int          sink_gap  = 0;
    int          sink_hold = 0;
    bit          idle_on   = 1'b1;

    quadrature_lut_mixer_unit u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // LO value: full-wave cosine rounded and shifted by the sample width
    function automatic longint osc_lo(int k);
        bit     neg;
        longint v;
        neg = 1'b0;
        k = k % 200;
        if (k > 100) begin
            k = 200 - k;
        end
        if (k > 50) begin
            k = 100 - k;
            neg = 1'b1;
        end
        v = neg ? -COS_QTR[k] : COS_QTR[k];
        return (v + 2048) >>> 12;
    endfunction

    function automatic t_mix mix_round(t_sample rf, longint lo);
        longint rfl;
        longint p;
        rfl = rf;
        p = (rfl * lo + (64'sd1 <<< 13)) >>> 14;
        if (p > 32767) begin
            p = 32767;
        end
        if (p < -32768) begin
            p = -32768;
        end
        return t_mix'(p[15:0]);
    endfunction

    task automatic predict_mix(input t_sample rf);
        t_mix_beat b;
        int        qph;
        qph = (int'(osc_phase) + 50) % 200;
        b.in_phase   = mix_round(rf, osc_lo(osc_phase));
        b.quadrature = mix_round(rf, osc_lo(qph));
        mix_expect_q.push_back(b);
        osc_phase = 8'((int'(osc_phase) + int'(osc_band)) % 200);
    endtask

    task automatic flag_mismatch(input string msg);
        $display("MISMATCH @%0t: %s", $realtime, msg);
        err_count++;
    endtask

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                predict_mix(t_sample'(s_axis_tdata[11:0]));
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (src_gap > 0) begin
                    src_gap--;
                    s_axis_tvalid <= 1'b0;
                end else if (rf_q.size() > 0) begin
                    s_axis_tdata  <= {4'b0, rf_q.pop_front()};
                    s_axis_tvalid <= 1'b1;
                    if (idle_on && $urandom_range(0, 7) == 0) begin
                        src_gap = $urandom_range(1, 15);
                    end
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_mix_beat exp_b;
        t_mix      got_i;
        t_mix      got_q;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                got_i = m_axis_tdata[15:0];
                got_q = m_axis_tdata[31:16];
                if (mix_expect_q.size() == 0) begin
                    flag_mismatch($sformatf("unexpected beat I=%0d Q=%0d", got_i, got_q));
                end else begin
                    exp_b = mix_expect_q.pop_front();
                    n_checked++;
                    if (got_i !== exp_b.in_phase) begin
                        flag_mismatch($sformatf("beat %0d in_phase got %0d exp %0d",
                            n_checked, got_i, exp_b.in_phase));
                    end
                    if (got_q !== exp_b.quadrature) begin
                        flag_mismatch($sformatf("beat %0d quadrature got %0d exp %0d",
                            n_checked, got_q, exp_b.quadrature));
                    end
                end
            end
            if (sink_hold > 0) begin
                sink_hold--;
                m_axis_tready <= 1'b0;
            end else if (sink_gap > 0) begin
                sink_gap--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
                if (idle_on && $urandom_range(0, 7) == 0) begin
                    sink_gap = $urandom_range(1, 15);
                end
            end
        end
    end

    function automatic t_sample rand_rf();
        case ($urandom_range(0, 9))
            0:       return t_sample'(12'h800);
            1:       return t_sample'(12'h7ff);
            default: return t_sample'($urandom_range(0, 4095));
        endcase
    endfunction

    task automatic wait_drained();
        while (rf_q.size() != 0 || s_axis_tvalid || mix_expect_q.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (4) @(negedge i_clk);
    endtask

    // only called with the pipe empty, so the phase clear lines up with the block
    task automatic write_band(input logic [6:0] b);
        wait_drained();
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= b;
        @(posedge i_clk);
        i_cfg_we  <= 1'b0;
        osc_band  = b;
        osc_phase = '0;
        n_writes++;
        @(negedge i_clk);
    endtask

    initial begin
        logic [6:0] bands [7];
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // band 0 from reset: extremes of the sample at phase zero
        rf_q.push_back(t_sample'(12'h7ff));
        rf_q.push_back(t_sample'(12'h800));
        rf_q.push_back(t_sample'(12'h000));
        rf_q.push_back(t_sample'(12'hfff));
        rf_q.push_back(t_sample'(12'h001));

        // band 100 toggles between +1.0 and -1.0; most negative sample saturates
        write_band(7'd100);
        repeat (4) rf_q.push_back(t_sample'(12'h800));

        // band 50 walks the quarter points, quadrature hits -1.0 too
        write_band(7'd50);
        repeat (4) rf_q.push_back(t_sample'(12'h800));
        repeat (4) rf_q.push_back(t_sample'(12'h7ff));

        // band above the nominal range
        write_band(7'd127);
        repeat (4) rf_q.push_back(rand_rf());

        bands[0] = 7'd1;
        bands[1] = 7'd127;
        bands[2] = 7'($urandom_range(0, 127));
        bands[3] = 7'd0;
        bands[4] = 7'($urandom_range(101, 127));
        bands[5] = 7'($urandom_range(0, 127));
        bands[6] = 7'($urandom_range(0, 127));

        for (int ph = 0; ph < 7; ph++) begin
            if (ph == 6) begin
                idle_on = 1'b0;
            end
            write_band(bands[ph]);
            if (ph == 3) begin
                // receiver stalls long while the sender keeps offering
                sink_hold = 300;
            end
            repeat (225) rf_q.push_back(rand_rf());
        end

        while (rf_q.size() != 0 || s_axis_tvalid) begin
            @(negedge i_clk);
        end
        wait_drained();

        $display("Checked %0d mixed beats over %0d band settings (0, 50, 100, 127 and random),",
            n_checked, n_writes + 1);
        $display("with full-scale samples, random idling and a long output stall.");
        if (err_count == 0) begin
            $display("** quadrature_lut_mixer_unit: PASSED **");
        end else begin
            $display("** quadrature_lut_mixer_unit: FAILED **");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("Timeout with %0d beats still expected", mix_expect_q.size());
        $display("** quadrature_lut_mixer_unit: FAILED **");
        $finish;
    end

endmodule

FILE: files.f
rtl/qlm_pkg.sv
rtl/qlm_mixer.sv
rtl/quadrature_lut_mixer_unit.sv
sim/tb_quadrature_lut_mixer_unit.sv
